FILE: rtl/nearest_value_sorted_set_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest value sorted set.
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NEAREST_VALUE_SORTED_SET_MACROS_SVH
`define NEAREST_VALUE_SORTED_SET_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NVS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nvs_pkg.sv
// ----------------------------------------------------------------------------
// nvs_pkg
// Types and constants shared by the nearest value sorted set modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nvs_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QFILL_W  = $clog2(QDEPTH + 1);
  localparam int OUT_W    = 1 + KEY_W + STATUS_W + ENTRY_W;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXE
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/nvs_front.sv
// ----------------------------------------------------------------------------
// nvs_front
// Accepts input transactions, decodes the operation and registers a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nvs_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [nvs_pkg::KEY_W-1:0]   s_tdata,
  input  wire logic [nvs_pkg::FUNC_W-1:0]  s_tuser,
  output logic                             cmd_valid,
  output nvs_pkg::cmd_t                    cmd,
  input  wire logic                        cmd_ready
);

  nvs_pkg::cmd_t cmd_next;

  assign s_tready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.key = $signed(s_tdata);
    unique case (s_tuser)
      nvs_pkg::OP_INSERT: cmd_next.op = nvs_pkg::OP_INSERT;
      nvs_pkg::OP_QUERY:  cmd_next.op = nvs_pkg::OP_QUERY;
      nvs_pkg::OP_CLEAR:  cmd_next.op = nvs_pkg::OP_CLEAR;
      default:            cmd_next.op = nvs_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nvs_queue.sv
// ----------------------------------------------------------------------------
// nvs_queue
// Short command queue that decouples the decoder from the execution unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nvs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire nvs_pkg::cmd_t  push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output nvs_pkg::cmd_t       pop_cmd
);

  nvs_pkg::cmd_t                   entries [nvs_pkg::QDEPTH];
  logic [nvs_pkg::QPTR_W-1:0]      wr_ptr;
  logic [nvs_pkg::QPTR_W-1:0]      rd_ptr;
  logic [nvs_pkg::QFILL_W-1:0]     fill;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = fill != nvs_pkg::QFILL_W'(nvs_pkg::QDEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nvs_back.sv
// ----------------------------------------------------------------------------
// nvs_back
// Sorted cell array with compare and execute steps and a result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nvs_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  output logic                            cmd_ready,
  input  wire nvs_pkg::cmd_t              cmd,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [nvs_pkg::OUT_W-1:0]       m_tdata
);

  localparam int N = nvs_pkg::CAPACITY;

  nvs_pkg::state_t                   state;
  nvs_pkg::state_t                   state_next;
  nvs_pkg::cmd_t                     cur;
  logic signed [nvs_pkg::KEY_W-1:0]  cells [N];
  logic signed [nvs_pkg::KEY_W-1:0]  cells_next [N];
  logic [nvs_pkg::CNT_W-1:0]         count;
  logic [nvs_pkg::CNT_W-1:0]         count_next;
  logic [N-1:0]                      lt;
  logic [N-1:0]                      eq;
  logic [N-1:0]                      lt_next;
  logic [N-1:0]                      eq_next;
  logic [N-1:0]                      sel_lo;
  logic [N-1:0]                      sel_hi;
  logic signed [nvs_pkg::KEY_W-1:0]  lo_val;
  logic signed [nvs_pkg::KEY_W-1:0]  hi_val;
  logic signed [nvs_pkg::KEY_W:0]    dist_lo;
  logic signed [nvs_pkg::KEY_W:0]    dist_hi;
  logic                              out_free;
  logic                              exe;
  logic                              res_found;
  logic signed [nvs_pkg::KEY_W-1:0]  res_value;
  nvs_pkg::status_t                  res_status;
  logic                              out_found;
  logic signed [nvs_pkg::KEY_W-1:0]  out_value;
  nvs_pkg::status_t                  out_status;
  logic [nvs_pkg::ENTRY_W-1:0]       out_count;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      nvs_pkg::S_IDLE: if (cmd_valid) state_next = nvs_pkg::S_CMP;
      nvs_pkg::S_CMP:  state_next = nvs_pkg::S_EXE;
      nvs_pkg::S_EXE: begin
        if (out_free) begin
          state_next = cmd_valid ? nvs_pkg::S_CMP : nvs_pkg::S_IDLE;
        end
      end
      default: state_next = nvs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    exe       = 1'b0;
    unique case (state)
      nvs_pkg::S_IDLE: cmd_ready = 1'b1;
      nvs_pkg::S_CMP:  cmd_ready = 1'b0;
      nvs_pkg::S_EXE: begin
        cmd_ready = out_free;
        exe       = out_free;
      end
      default: cmd_ready = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      lt_next[i] = (nvs_pkg::CNT_W'(i) < count) && (cells[i] < cur.key);
      eq_next[i] = (nvs_pkg::CNT_W'(i) < count) && (cells[i] == cur.key);
    end
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < N; i++) begin
      sel_lo[i] = lt[i] && ((i == N - 1) || !lt[(i + 1) % N]);
      sel_hi[i] = !lt[i] && (nvs_pkg::CNT_W'(i) < count) && ((i == 0) || lt[(i + N - 1) % N]);
      lo_val    = lo_val | (cells[i] & {nvs_pkg::KEY_W{sel_lo[i]}});
      hi_val    = hi_val | (cells[i] & {nvs_pkg::KEY_W{sel_hi[i]}});
    end
    dist_lo = $signed({cur.key[nvs_pkg::KEY_W-1], cur.key}) -
              $signed({lo_val[nvs_pkg::KEY_W-1], lo_val});
    dist_hi = $signed({hi_val[nvs_pkg::KEY_W-1], hi_val}) -
              $signed({cur.key[nvs_pkg::KEY_W-1], cur.key});
  end

  always_comb begin
    cells_next = cells;
    count_next = count;
    res_found  = 1'b0;
    res_value  = '0;
    res_status = nvs_pkg::STAT_OK;
    case (cur.op)
      nvs_pkg::OP_INSERT: begin
        if (|eq) begin
          res_status = nvs_pkg::STAT_DUP;
        end else if (count == nvs_pkg::CNT_W'(N)) begin
          res_status = nvs_pkg::STAT_FULL;
        end else begin
          for (int i = 0; i < N; i++) begin
            if (!lt[i]) begin
              if ((i == 0) || lt[(i + N - 1) % N]) begin
                cells_next[i] = cur.key;
              end else begin
                cells_next[i] = cells[(i + N - 1) % N];
              end
            end
          end
          count_next = count + 1'b1;
        end
      end
      nvs_pkg::OP_QUERY: begin
        if (count != '0) begin
          res_found = 1'b1;
          if (!(|lt)) begin
            res_value = hi_val;
          end else if (!(|sel_hi)) begin
            res_value = lo_val;
          end else begin
            res_value = (dist_lo <= dist_hi) ? lo_val : hi_val;
          end
        end
      end
      nvs_pkg::OP_CLEAR: count_next = '0;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nvs_pkg::S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (exe) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cur <= cmd;
    end
    if (state == nvs_pkg::S_CMP) begin
      lt <= lt_next;
      eq <= eq_next;
    end
    if (exe) begin
      cells      <= cells_next;
      out_found  <= res_found;
      out_value  <= res_value;
      out_status <= res_status;
      out_count  <= nvs_pkg::ENTRY_W'(count_next);
    end
  end

  assign m_tdata = {out_count, out_status, out_value, out_found};

endmodule

`default_nettype wire

FILE: rtl/nearest_value_sorted_set.sv
// ----------------------------------------------------------------------------
// nearest_value_sorted_set
// Ordered set of distinct signed values with insert, clear and nearest query.
//
// Input stream: s_tuser carries the operation (insert, query, clear), s_tdata
// carries the key. Every input transaction yields exactly one output
// transaction on the m_ group with found, nearest value, status and count.
// A decoder stage and a two-entry command queue sit in front of the
// execution unit, so input transactions are taken while a result waits.
// For each operation the execution unit first compares the key against all
// cells in parallel, then shifts cells or selects the neighbors and
// registers the result. It accepts the next command while it registers
// the current result, unless the receiver holds the output stalled.
// Reset empties the set and drops any queued commands; it needs no
// clearing pass. When the receiver holds m_tready low, the result stays
// stable, the queue fills, and s_tready falls once the queue and decoder
// register are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_value_sorted_set_macros.svh"

module nearest_value_sorted_set (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // key
  input  wire logic [1:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // found, nearest_value, status, entry_count
);

  logic          f_valid;
  logic          f_ready;
  nvs_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_ready;
  nvs_pkg::cmd_t q_cmd;

  nvs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  nvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  nvs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  `NVS_ASSERT_SAME(a_count_range, m_tvalid, m_tdata[39:35] <= 5'(nvs_pkg::CAPACITY), "count above capacity")
  `NVS_ASSERT_SAME(a_full_count, m_tvalid && m_tdata[34:33] == nvs_pkg::STAT_FULL, m_tdata[39:35] == 5'(nvs_pkg::CAPACITY), "full status with room left")
  `NVS_ASSERT_SAME(a_found_ok, m_tvalid && m_tdata[0], m_tdata[34:33] == nvs_pkg::STAT_OK && m_tdata[39:35] != 5'd0, "found on empty set or with error status")
  `NVS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

endmodule

`default_nettype wire

FILE: dv/nearest_value_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_value_check
// Watches both stream channels of the nearest value sorted set. It keeps its
// own ordered copy of the set, works out the result of every accepted input
// transaction, and compares each output transaction field by field against
// the oldest outstanding result. It counts the failures and the results
// still outstanding.
// ----------------------------------------------------------------------------
module nearest_value_check
  import nvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // key
  input  logic [1:0]  s_tuser,   // func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // found, nearest_value, status, entry_count
  output int          errors,
  output int          pending
);

  typedef struct {
    logic                    found;
    logic signed [KEY_W-1:0] nearest;
    logic [STATUS_W-1:0]     status;
    logic [ENTRY_W-1:0]      count;
  } set_result_t;

  logic signed [KEY_W-1:0] held_values [CAPACITY];
  int                      held_count;
  set_result_t             result_q [$];

  initial begin
    errors     = 0;
    pending    = 0;
    held_count = 0;
  end

  function automatic set_result_t apply_op(op_t op, logic signed [KEY_W-1:0] key);
    set_result_t r;
    int          pos;
    longint      lo;
    longint      hi;
    r.found   = 1'b0;
    r.nearest = '0;
    r.status  = STAT_OK;
    pos = 0;
    while (pos < held_count && held_values[pos] < key) pos++;
    case (op)
      OP_INSERT: begin
        if (pos < held_count && held_values[pos] == key) begin
          r.status = STAT_DUP;
        end else if (held_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (int j = held_count; j > pos; j--) held_values[j] = held_values[j-1];
          held_values[pos] = key;
          held_count++;
        end
      end
      OP_QUERY: begin
        if (held_count > 0) begin
          r.found = 1'b1;
          if (pos == 0) begin
            r.nearest = held_values[0];
          end else if (pos >= held_count) begin
            r.nearest = held_values[held_count-1];
          end else begin
            lo = held_values[pos-1];
            hi = held_values[pos];
            r.nearest = (longint'(key) - lo <= hi - longint'(key)) ? held_values[pos-1]
                                                                   : held_values[pos];
          end
        end
      end
      OP_CLEAR: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    r.count = ENTRY_W'(held_count);
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          compare_field("found", want.found, m_tdata[0]);
          compare_field("nearest_value", want.nearest, $signed(m_tdata[32:1]));
          compare_field("status", want.status, m_tdata[34:33]);
          compare_field("entry_count", want.count, m_tdata[39:35]);
        end
      end
      if (s_tvalid && s_tready) begin
        result_q.push_back(apply_op(op_t'(s_tuser), $signed(s_tdata)));
      end
    end
    pending = result_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the nearest value sorted set. A directed opening
// covers the empty set, the key extremes, duplicates, ties, clear and the
// unused operation code; random episodes of inserts and queries over wide,
// narrow and extreme keys then fill the store to capacity and beyond. Both
// sides idle in random bursts, but not in quiet episodes or near the end.
// ----------------------------------------------------------------------------
module testbench;
  import nvs_pkg::*;

  localparam int RANDOM_OPS = 1700;
  localparam int CALM_AFTER = 1500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // key
  logic [1:0]  s_tuser = '0;   // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // found, nearest_value, status, entry_count
  logic        quiet = 1'b0;
  int          stall_left = 0;
  int          errors;
  int          pending;

  nearest_value_sorted_set i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  nearest_value_check i_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (!rst && !quiet && $urandom_range(0, 99) < 15) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(1, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_op(op_t op, logic [31:0] key);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key(int flavor);
    logic [31:0] k;
    case (flavor)
      0: k = $urandom();
      1: k = 32'($urandom_range(0, 40)) - 32'd20;
      default: begin
        case ($urandom_range(0, 3))
          0: k = 32'h8000_0000 + 32'($urandom_range(0, 3));
          1: k = 32'h7fff_ffff - 32'($urandom_range(0, 3));
          2: k = 32'($urandom_range(0, 4)) - 32'd2;
          default: k = $urandom();
        endcase
      end
    endcase
    return k;
  endfunction

  initial begin
    int   sent;
    int   flavor;
    int   span;
    int   roll;
    op_t  op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_op(OP_QUERY,  32'd5);
    send_op(OP_NOP,    32'hffff_ffff);
    send_op(OP_INSERT, 32'd0);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h7fff_ffff);
    send_op(OP_INSERT, 32'd0);
    send_op(OP_QUERY,  32'h8000_0000);
    send_op(OP_QUERY,  32'h7fff_ffff);
    send_op(OP_QUERY,  32'd1);
    send_op(OP_QUERY,  32'hffff_ffff);
    send_op(OP_INSERT, 32'd10);
    send_op(OP_QUERY,  32'd5);
    send_op(OP_QUERY,  32'd6);
    send_op(OP_QUERY,  32'h7fff_fffe);
    send_op(OP_QUERY,  32'h8000_0001);
    send_op(OP_QUERY,  32'h3fff_ffff);
    send_op(OP_NOP,    32'd0);
    send_op(OP_CLEAR,  32'h5555_5555);
    send_op(OP_QUERY,  32'haaaa_aaaa);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_QUERY,  32'h7fff_ffff);
    send_op(OP_CLEAR,  32'd0);

    sent = 0;
    while (sent < RANDOM_OPS) begin
      quiet  <= (sent >= CALM_AFTER) || ($urandom_range(0, 99) < 20);
      flavor = $urandom_range(0, 2);
      span   = $urandom_range(8, 40);
      if ($urandom_range(0, 99) < 70) begin
        send_op(OP_CLEAR, $urandom());
        sent++;
      end
      for (int i = 0; i < span; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) op = OP_INSERT;
        else if (roll < 93) op = OP_QUERY;
        else if (roll < 95) op = OP_CLEAR;
        else op = OP_NOP;
        send_op(op, pick_key(flavor));
        sent++;
      end
    end
    s_tvalid <= 1'b0;
    quiet    <= 1'b1;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: nearest_value_sorted_set.f
+incdir+rtl
rtl/nvs_pkg.sv
rtl/nvs_front.sv
rtl/nvs_queue.sv
rtl/nvs_back.sv
rtl/nearest_value_sorted_set.sv
dv/nearest_value_check.sv
dv/testbench.sv
